>>> sv/dmconv_pkg.sv
package dmconv_pkg;

    // Number of matrix elements carried by one item.
    localparam int unsigned LANES = 9;

    // IEEE-754 double layout.
    localparam int unsigned MANT_W   = 52;
    localparam int unsigned EXP_W    = 11;
    localparam int unsigned SIG_W    = MANT_W + 1;
    localparam int unsigned WORD_W   = 64;
    localparam int unsigned INT_W    = 31;
    localparam int unsigned FRAC_W   = 32;

    // The scaled fraction (f * 2^32 - f) needs 53 + 32 bits.
    localparam int unsigned PROD_W   = SIG_W + FRAC_W;
    localparam int unsigned SHIFT_W  = 7;

    // Exponent codes that bound the normal conversion path.
    localparam logic [EXP_W-1:0] EXP_ALL_ONES = 11'h7FF;
    localparam logic [EXP_W-1:0] EXP_ONE      = 11'd1023;
    // Below this exponent the scaled fraction stays under one half.
    localparam logic [EXP_W-1:0] EXP_FRAC_MIN = 11'd990;
    // From this exponent on the integer part needs 32 bits or more.
    localparam logic [EXP_W-1:0] EXP_SAT      = 11'd1054;
    // Shift that brings the binary point to bit zero: 1023 + 52.
    localparam logic [EXP_W-1:0] EXP_SHIFT0   = 11'd1075;

    localparam logic [WORD_W-2:0] MAG_SAT = {(WORD_W-1){1'b1}};

    // How a lane treats its element.
    typedef enum logic [1:0] {
        KIND_NORMAL,
        KIND_ZERO_FRAC,
        KIND_SAT,
        KIND_NAN
    } kind_t;

    // What one lane hands to the merging stage.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              ovf;
    } lane_res_t;

endpackage

>>> sv/dmconv_lane.sv
module dmconv_lane
    import dmconv_pkg::*;
(
    input  logic              clk,
    input  logic [WORD_W-1:0] elem,
    output lane_res_t         res
);

    // Stage one: decode the double and scale its fraction.
    logic [EXP_W-1:0]   expo;
    logic [SIG_W-1:0]   sig;
    logic [SIG_W-1:0]   fbits;
    logic [SHIFT_W-1:0] sh;
    logic               sign;
    kind_t              kind;

    logic               sign1_reg;
    kind_t              kind1_reg;
    logic [INT_W-1:0]   int1_reg;
    logic [PROD_W-1:0]  q1_reg;
    logic [SHIFT_W-1:0] sh1_reg;

    assign expo  = elem[WORD_W-2 -: EXP_W];
    assign sig   = {1'b1, elem[MANT_W-1:0]};
    assign sign  = elem[WORD_W-1] & (elem[WORD_W-2:0] != '0);
    assign sh    = SHIFT_W'(EXP_SHIFT0 - expo);
    assign fbits = sig & ~({SIG_W{1'b1}} << sh);

    always_comb
    begin
        if (expo == EXP_ALL_ONES)
        begin
            kind = (elem[MANT_W-1:0] != '0) ? KIND_NAN : KIND_SAT;
        end
        else if (expo >= EXP_SAT)
        begin
            kind = KIND_SAT;
        end
        else if (expo < EXP_FRAC_MIN)
        begin
            kind = KIND_ZERO_FRAC;
        end
        else
        begin
            kind = KIND_NORMAL;
        end
    end

    always_ff @(posedge clk)
    begin
        sign1_reg <= sign;
        kind1_reg <= kind;
        sh1_reg   <= sh;
        int1_reg  <= (expo >= EXP_ONE) ? INT_W'(sig >> sh) : '0;
        q1_reg    <= (PROD_W'(fbits) << FRAC_W) - PROD_W'(fbits);
    end

    // Stage two: integer part of the product and the distance to the next integer.
    logic [PROD_W-1:0]  nq;
    logic [SHIFT_W-1:0] lsh;

    logic               sign2_reg;
    kind_t              kind2_reg;
    logic [INT_W-1:0]   int2_reg;
    logic [FRAC_W-1:0]  pfl2_reg;
    logic [PROD_W-1:0]  dist2_reg;

    assign nq  = ~q1_reg + PROD_W'(1);
    assign lsh = SHIFT_W'(PROD_W) - sh1_reg;

    always_ff @(posedge clk)
    begin
        sign2_reg <= sign1_reg;
        kind2_reg <= kind1_reg;
        int2_reg  <= int1_reg;
        pfl2_reg  <= FRAC_W'(q1_reg >> sh1_reg);
        dist2_reg <= nq << lsh;
    end

    // Stage three: round-to-nearest of the product can lift it to the next integer.
    logic [FRAC_W-1:0] pref;
    logic [FRAC_W-1:0] top_bit;
    logic [PROD_W-1:0] thr;
    logic              up;
    logic [FRAC_W-1:0] frac;

    always_comb
    begin
        pref = pfl2_reg;
        pref = pref | (pref >> 1);
        pref = pref | (pref >> 2);
        pref = pref | (pref >> 4);
        pref = pref | (pref >> 8);
        pref = pref | (pref >> 16);
    end

    assign top_bit = pref & ~(pref >> 1);
    assign thr     = (pfl2_reg == '0) ? (PROD_W'(1) << (FRAC_W - 1))
                                      : (PROD_W'(top_bit) << FRAC_W);
    assign up      = (dist2_reg != '0) && (dist2_reg <= thr);
    assign frac    = pfl2_reg + FRAC_W'(up);

    always_ff @(posedge clk)
    begin
        case (kind2_reg)
            KIND_NAN:
            begin
                res.word <= '0;
                res.ovf  <= 1'b1;
            end
            KIND_SAT:
            begin
                res.word <= {sign2_reg, MAG_SAT};
                res.ovf  <= 1'b1;
            end
            KIND_ZERO_FRAC:
            begin
                res.word <= {sign2_reg, {(WORD_W-1){1'b0}}};
                res.ovf  <= 1'b0;
            end
            default:
            begin
                res.word <= {sign2_reg, int2_reg, frac};
                res.ovf  <= 1'b0;
            end
        endcase
    end

endmodule

>>> sv/dmconv_merge.sv
module dmconv_merge
    import dmconv_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    valid,
    input  lane_res_t [LANES-1:0]   lane_res,
    output logic [WORD_W-1:0]       words [LANES],
    output logic [LANES-1:0]        mask,
    output logic                    done
);

    logic [WORD_W-1:0] words_reg [LANES];
    logic [LANES-1:0]  mask_reg;
    logic              done_reg;

    // Collect the lane words and gather their flags into one mask.
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < LANES; k++)
        begin
            words_reg[k] <= lane_res[k].word;
            mask_reg[k]  <= lane_res[k].ovf;
        end
    end

    // The strobe follows the item through the final register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    assign words = words_reg;
    assign mask  = mask_reg;
    assign done  = done_reg;

endmodule

>>> sv/double_matrix_to_s31_32_converter_unit.sv
// Channel   Ports                               Handshake
// input     elem_r0c0 .. elem_r2c2              start high while busy low
// result    fix_r0c0 .. fix_r2c2, overflow_mask done high for one cycle
//
// A new matrix is taken every cycle; each of the nine lanes runs three stages
// and the merging register adds one more. busy is never raised, as every
// stage advances each cycle. Reset clears only the valid pipeline; the
// receiver cannot stall results.
module double_matrix_to_s31_32_converter_unit
    import dmconv_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [WORD_W-1:0] elem_r0c0,
    input  logic [WORD_W-1:0] elem_r0c1,
    input  logic [WORD_W-1:0] elem_r0c2,
    input  logic [WORD_W-1:0] elem_r1c0,
    input  logic [WORD_W-1:0] elem_r1c1,
    input  logic [WORD_W-1:0] elem_r1c2,
    input  logic [WORD_W-1:0] elem_r2c0,
    input  logic [WORD_W-1:0] elem_r2c1,
    input  logic [WORD_W-1:0] elem_r2c2,
    output logic              done,
    output logic [WORD_W-1:0] fix_r0c0,
    output logic [WORD_W-1:0] fix_r0c1,
    output logic [WORD_W-1:0] fix_r0c2,
    output logic [WORD_W-1:0] fix_r1c0,
    output logic [WORD_W-1:0] fix_r1c1,
    output logic [WORD_W-1:0] fix_r1c2,
    output logic [WORD_W-1:0] fix_r2c0,
    output logic [WORD_W-1:0] fix_r2c1,
    output logic [WORD_W-1:0] fix_r2c2,
    output logic [LANES-1:0]  overflow_mask
);

    logic [WORD_W-1:0]      elems [LANES];
    logic [WORD_W-1:0]      words [LANES];
    lane_res_t [LANES-1:0]  lane_res;
    logic [2:0]             valid_reg;
    logic [2:0]             valid_next;

    assign busy = 1'b0;

    assign elems[0] = elem_r0c0;
    assign elems[1] = elem_r0c1;
    assign elems[2] = elem_r0c2;
    assign elems[3] = elem_r1c0;
    assign elems[4] = elem_r1c1;
    assign elems[5] = elem_r1c2;
    assign elems[6] = elem_r2c0;
    assign elems[7] = elem_r2c1;
    assign elems[8] = elem_r2c2;

    // One conversion lane for each element.
    for (genvar k = 0; k < LANES; k++)
    begin : g_lane
        dmconv_lane u_lane (
            .clk  (clk),
            .elem (elems[k]),
            .res  (lane_res[k])
        );
    end

    // Valid bits that walk alongside the lane stages.
    assign valid_next = {valid_reg[1:0], start & ~busy};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    dmconv_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .valid    (valid_reg[2]),
        .lane_res (lane_res),
        .words    (words),
        .mask     (overflow_mask),
        .done     (done)
    );

    assign fix_r0c0 = words[0];
    assign fix_r0c1 = words[1];
    assign fix_r0c2 = words[2];
    assign fix_r1c0 = words[3];
    assign fix_r1c1 = words[4];
    assign fix_r1c2 = words[5];
    assign fix_r2c0 = words[6];
    assign fix_r2c1 = words[7];
    assign fix_r2c2 = words[8];

endmodule

>>> dv/dmconv_checker.sv
`timescale 1ns / 1ps

// Watches the input and result channels of the converter, works out the
// expected S31.32 words for every accepted item and compares them in order.
module dmconv_checker
    import dmconv_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic [LANES-1:0][WORD_W-1:0] elems,
    input  logic                         done,
    input  logic [LANES-1:0][WORD_W-1:0] fixes,
    input  logic [LANES-1:0]             overflow_mask,
    output int                           fail_count,
    output int                           pending,
    output int                           results_seen,
    output int                           flagged_lanes
);

    typedef struct packed {
        logic [LANES-1:0][WORD_W-1:0] words;
        logic [LANES-1:0]             mask;
    } matrix_fix_t;

    matrix_fix_t expected_fixes[$];

    // Truncates a non-negative double below 2^32 to an integer.
    function automatic logic [31:0] trunc_to_u32(real value);
        logic [63:0] bits;
        logic [10:0] ex;
        logic [52:0] sig;
        logic [52:0] shifted;
        int          sh;
        bits = $realtobits(value);
        ex   = bits[62:52];
        sig  = {1'b1, bits[51:0]};
        if (ex < EXP_ONE)
            return '0;
        sh      = int'(ex) - int'(EXP_ONE);
        shifted = sig >> (MANT_W - sh);
        return shifted[31:0];
    endfunction

    // Scales a fraction by 2^32-1 with the double rounding kept.
    function automatic logic [31:0] scale_fraction(real f);
        real p;
        p = f * 4294967295.0;
        if (!(p >= 0.0))
            return '0;
        if (p >= 4294967295.0)
            return 32'hFFFF_FFFF;
        return trunc_to_u32(p);
    endfunction

    // Converts one raw double to a sign-magnitude word and its flag.
    function automatic logic [WORD_W-1:0] convert_elem(logic [63:0] bits, output logic ovf);
        logic [62:0] mag;
        logic [10:0] ex;
        logic [51:0] mant;
        logic        sgn;
        logic [52:0] sig;
        logic [63:0] ipart;
        logic [63:0] fbits;
        int          sh;
        real         fd;
        mag  = bits[62:0];
        ex   = bits[62:52];
        mant = bits[51:0];
        sgn  = bits[63] && (mag != 0);
        ovf  = 1'b0;
        if (ex == EXP_ALL_ONES)
        begin
            ovf = 1'b1;
            if (mant != 0)
                return '0;
            return {sgn, MAG_SAT};
        end
        if (ex < EXP_ONE)
        begin
            fd = $bitstoreal({1'b0, mag});
            return {sgn, 31'd0, scale_fraction(fd)};
        end
        if (ex >= EXP_SAT)
        begin
            ovf = 1'b1;
            return {sgn, MAG_SAT};
        end
        sig   = {1'b1, mant};
        sh    = MANT_W - (int'(ex) - int'(EXP_ONE));
        ipart = 64'(sig) >> sh;
        fbits = 64'(sig) & ((64'd1 << sh) - 64'd1);
        fd    = real'(fbits) / real'(64'd1 << sh);
        return {sgn, ipart[30:0], scale_fraction(fd)};
    endfunction

    function automatic matrix_fix_t convert_matrix(logic [LANES-1:0][WORD_W-1:0] m);
        matrix_fix_t r;
        logic        ovf;
        for (int k = 0; k < LANES; k++)
        begin
            r.words[k] = convert_elem(m[k], ovf);
            r.mask[k]  = ovf;
        end
        return r;
    endfunction

    // Record accepted items and compare each result with the oldest one.
    always @(posedge clk or negedge rst_n)
    begin
        matrix_fix_t want;
        if (!rst_n)
        begin
            fail_count    <= 0;
            pending       <= 0;
            results_seen  <= 0;
            flagged_lanes <= 0;
        end
        else
        begin
            if (start && !busy)
                expected_fixes.push_back(convert_matrix(elems));
            if (done)
            begin
                results_seen <= results_seen + 1;
                if (expected_fixes.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("ERROR: result with no item outstanding at %0t", $realtime);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_fixes.pop_front();
                    flagged_lanes <= flagged_lanes + $countones(want.mask);
                    if (want != {fixes, overflow_mask})
                    begin
                        if (fail_count < 10)
                        begin
                            $display("ERROR: mismatch at %0t", $realtime);
                            for (int k = 0; k < LANES; k++)
                                if (want.words[k] != fixes[k])
                                    $display("  lane %0d expected %h got %h", k,
                                             want.words[k], fixes[k]);
                            if (want.mask != overflow_mask)
                                $display("  overflow mask expected %b got %b",
                                         want.mask, overflow_mask);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_fixes.size() + ((start && !busy) ? 1 : 0) - (done ? 1 : 0)
                       - ((start && !busy) ? 1 : 0) + (done ? 1 : 0);
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
    import dmconv_pkg::*;

    logic                         clk;
    logic                         rst_n;
    logic                         start;
    logic                         busy;
    logic [LANES-1:0][WORD_W-1:0] elems;
    logic                         done;
    logic [LANES-1:0][WORD_W-1:0] fixes;
    logic [LANES-1:0]             overflow_mask;
    int                           fail_count;
    int                           pending;
    int                           results_seen;
    int                           flagged_lanes;
    int                           items_sent;

    double_matrix_to_s31_32_converter_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .elem_r0c0    (elems[0]),
        .elem_r0c1    (elems[1]),
        .elem_r0c2    (elems[2]),
        .elem_r1c0    (elems[3]),
        .elem_r1c1    (elems[4]),
        .elem_r1c2    (elems[5]),
        .elem_r2c0    (elems[6]),
        .elem_r2c1    (elems[7]),
        .elem_r2c2    (elems[8]),
        .done         (done),
        .fix_r0c0     (fixes[0]),
        .fix_r0c1     (fixes[1]),
        .fix_r0c2     (fixes[2]),
        .fix_r1c0     (fixes[3]),
        .fix_r1c1     (fixes[4]),
        .fix_r1c2     (fixes[5]),
        .fix_r2c0     (fixes[6]),
        .fix_r2c1     (fixes[7]),
        .fix_r2c2     (fixes[8]),
        .overflow_mask(overflow_mask)
    );

    dmconv_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .elems        (elems),
        .done         (done),
        .fixes        (fixes),
        .overflow_mask(overflow_mask),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .flagged_lanes(flagged_lanes)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Interesting doubles: zeros, subnormals, limits of the integer range,
    // infinities and NaNs of both signs.
    function automatic logic [63:0] edge_double(int idx);
        case (idx % 20)
            0:  return 64'h0000_0000_0000_0000;
            1:  return 64'h8000_0000_0000_0000;
            2:  return 64'h0000_0000_0000_0001;
            3:  return 64'h800F_FFFF_FFFF_FFFF;
            4:  return 64'h7FF0_0000_0000_0000;
            5:  return 64'hFFF0_0000_0000_0000;
            6:  return 64'h7FF8_0000_0000_0000;
            7:  return 64'hFFFF_FFFF_FFFF_FFFF;
            8:  return 64'h7FF0_0000_0000_0001;
            9:  return 64'h41DF_FFFF_FFFF_FFFF;
            10: return 64'h41E0_0000_0000_0000;
            11: return 64'hC1E0_0000_0000_0000;
            12: return 64'h7FEF_FFFF_FFFF_FFFF;
            13: return 64'h3FEF_FFFF_FFFF_FFFF;
            14: return 64'hBFE0_0000_0000_0000;
            15: return 64'h3FF0_0000_0000_0000;
            16: return 64'h3DF0_0000_0000_0000;
            17: return 64'h3E00_0000_0000_0001;
            18: return 64'hC1DF_FFFF_FFFF_FFFF;
            default: return 64'h3FF8_0000_0000_0001;
        endcase
    endfunction

    // Mostly values in the useful range, with raw bits and special codes mixed in.
    function automatic logic [63:0] random_double();
        logic [63:0] v;
        int          pick;
        v    = {$urandom, $urandom};
        pick = $urandom_range(0, 9);
        if (pick < 5)
            v[62:52] = 11'($urandom_range(985, 1058));
        else if (pick < 7)
        begin
            v[62:52] = 11'($urandom_range(1023, 1030));
            if ($urandom_range(0, 1))
                v[40:0] = '0;
        end
        else if (pick == 7)
            v = edge_double($urandom_range(0, 19));
        else if (pick == 8)
            v[62:52] = $urandom_range(0, 1) ? EXP_ALL_ONES : 11'd0;
        return v;
    endfunction

    task automatic send_matrix(logic [LANES-1:0][WORD_W-1:0] m, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        elems <= m;
        // Wait for the edge at which the item is taken.
        forever
        begin
            @(negedge clk);
            if (!busy)
                break;
        end
        @(posedge clk);
        items_sent++;
    endtask

    initial
    begin
        logic [LANES-1:0][WORD_W-1:0] m;
        bit                           bursty;
        start      = 1'b0;
        elems      = '0;
        items_sent = 0;
        rst_n      = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: every special value seen in every lane.
        for (int i = 0; i < 20; i++)
        begin
            for (int k = 0; k < LANES; k++)
                m[k] = edge_double(i + k);
            send_matrix(m, 1'b0);
        end

        // Random part, in runs of 50 items; each run is picked at random to have gaps or not.
        bursty = 1'b0;
        for (int i = 0; i < 930; i++)
        begin
            if (i % 50 == 0)
                bursty = $urandom_range(0, 1);
            for (int k = 0; k < LANES; k++)
                m[k] = random_double();
            send_matrix(m, !bursty);
        end
        start <= 1'b0;

        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d matrices, checked %0d results.", items_sent, results_seen);
        $display("Lanes flagged as NaN, infinite or saturated: %0d.", flagged_lanes);
        if (fail_count == 0)
            $display("PASS double_matrix_to_s31_32_converter_unit");
        else
            $display("FAIL double_matrix_to_s31_32_converter_unit");
        $finish;
    end

    initial
    begin
        #1ms;
        $display("FAIL double_matrix_to_s31_32_converter_unit");
        $finish;
    end

endmodule
